// ----- rtl/core/ctap_pkg.sv -----
// shared types and constants of the color to argb packer
package ctap_pkg;

    // field widths
    localparam int VAL_W   = 24;
    localparam int MAX_W   = 23;
    localparam int Q_W     = 17;
    localparam int FRAC_Q  = 16;
    localparam int NCH     = 4;
    localparam int DIV_STEPS = 16;

    // channel slots
    localparam int CH_X = 0;
    localparam int CH_Y = 1;
    localparam int CH_Z = 2;
    localparam int CH_A = 3;

    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    // request opcodes
    typedef enum logic [1:0] {
        OP_GRAY   = 2'd0,
        OP_THREE  = 2'd1,
        OP_PACKED = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_COLOR_MODE   = 3'd0,
        REG_SCALE_ENABLE = 3'd1,
        REG_MAX_X        = 3'd2,
        REG_MAX_Y        = 3'd3,
        REG_MAX_Z        = 3'd4,
        REG_MAX_ALPHA    = 3'd5
    } reg_index_t;

    // what the pipeline does with a beat
    typedef enum logic [1:0] {
        K_GRAY,
        K_THREE,
        K_PASS,
        K_NONE
    } kind_t;

    // side-band that travels with every beat
    typedef struct packed {
        kind_t                       kind;
        logic [31:0]                 pc;
        logic [NCH-1:0][MAX_W-1:0]   cval;
        logic                        alpha_eq;
        logic                        alpha_pos;
    } meta_t;

    // clamp a signed value to 0..mx
    function automatic logic [MAX_W-1:0] clamp_to(input logic signed [VAL_W:0] v,
                                                  input logic [MAX_W-1:0] mx);
        logic signed [VAL_W:0] mxs;
        mxs = $signed({2'b00, mx});
        if (v < 0) begin
            return '0;
        end else if (v > mxs) begin
            return mx;
        end
        return v[MAX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/color_to_argb_packer.sv -----
// color request to packed argb8888 converter, top level
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | opcode, has_alpha, x, y, z, alpha, packed
//  m_      | out       | m_valid / m_ready   | argb, translucent
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one beat per cycle while m_ready does not stall the output; stages: input stage,
// 16 divider steps, three hue stages and the output register
// the 16-step restoring divider (one quotient bit per stage) sets the depth
// a stall on m_ready freezes every stage at once; nothing is dropped
// synchronous active-low reset clears the valid bits and presets the config registers
module color_to_argb_packer
    import ctap_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic                    s_has_alpha,
    input  logic signed [VAL_W-1:0] s_value_x,
    input  logic signed [VAL_W-1:0] s_value_y,
    input  logic signed [VAL_W-1:0] s_value_z,
    input  logic signed [VAL_W-1:0] s_value_alpha,
    input  logic [31:0]             s_packed_color,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [31:0]             m_argb,
    output logic                    m_translucent,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [MAX_W-1:0]        cfg_data
);

    localparam int SH    = 16 - FRAC_BITS;
    localparam int LVL_W = MAX_W + 16 - FRAC_BITS;
    localparam int PCS_W = 32 + FRAC_BITS;

    // convert a q16 level to a saturated byte
    function automatic logic [7:0] to_byte(input logic [LVL_W-1:0] lvl);
        logic [LVL_W+7:0] prod;
        prod = {lvl, 8'd0} - {8'd0, lvl};
        if (|prod[LVL_W+7:24]) begin
            return 8'hff;
        end
        return prod[23:16];
    endfunction

    // configuration registers
    logic                   color_mode_reg;
    logic                   scale_enable_reg;
    logic [NCH-1:0][MAX_W-1:0] max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg   <= 1'b0;
            scale_enable_reg <= 1'b1;
            max_reg          <= {NCH{23'd65280}};
        end else if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                REG_SCALE_ENABLE: scale_enable_reg <= cfg_data[0];
                REG_MAX_X:        max_reg[CH_X]    <= cfg_data;
                REG_MAX_Y:        max_reg[CH_Y]    <= cfg_data;
                REG_MAX_Z:        max_reg[CH_Z]    <= cfg_data;
                REG_MAX_ALPHA:    max_reg[CH_A]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the output is stalled
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input decode
    logic signed [VAL_W:0]  alpha_in;
    logic [PCS_W-1:0]       pc_sh;
    logic                   pc_gray;
    meta_t                  meta_in;
    logic [NCH-1:0][MAX_W-1:0] dv_in;

    always_comb begin
        alpha_in = s_has_alpha ? {s_value_alpha[VAL_W-1], s_value_alpha}
                               : $signed({2'b00, max_reg[CH_A]});
        pc_sh    = {s_packed_color, {FRAC_BITS{1'b0}}};
        pc_gray  = (s_packed_color[31:24] == 8'd0) &&
                   (pc_sh <= {{(PCS_W-MAX_W){1'b0}}, max_reg[CH_X]});
        meta_in.pc        = s_packed_color;
        meta_in.alpha_eq  = (alpha_in == $signed({2'b00, max_reg[CH_A]}));
        meta_in.alpha_pos = (alpha_in > 0);
        meta_in.cval[CH_Y] = clamp_to({s_value_y[VAL_W-1], s_value_y}, max_reg[CH_Y]);
        meta_in.cval[CH_Z] = clamp_to({s_value_z[VAL_W-1], s_value_z}, max_reg[CH_Z]);
        meta_in.cval[CH_A] = clamp_to(alpha_in, max_reg[CH_A]);
        meta_in.cval[CH_X] = clamp_to({s_value_x[VAL_W-1], s_value_x}, max_reg[CH_X]);
        case (opcode_t'(s_opcode))
            OP_GRAY:  meta_in.kind = K_GRAY;
            OP_THREE: meta_in.kind = K_THREE;
            OP_PACKED: begin
                if (pc_gray) begin
                    meta_in.kind       = K_GRAY;
                    meta_in.cval[CH_X] = pc_sh[MAX_W-1:0];
                end else begin
                    meta_in.kind = K_PASS;
                end
            end
            default:  meta_in.kind = K_NONE;
        endcase
        dv_in = meta_in.cval;
    end

    // divider pipe: stage 0 takes the top quotient bit, stages 1..16 one bit each
    logic                       dvalid_reg [DIV_STEPS+1];
    meta_t                      dmeta_reg  [DIV_STEPS+1];
    logic [NCH-1:0][MAX_W-1:0]  rem_reg    [DIV_STEPS+1];
    logic [NCH-1:0][Q_W-1:0]    quot_reg   [DIV_STEPS+1];
    logic [NCH-1:0][MAX_W-1:0]  rem_next   [DIV_STEPS+1];
    logic [NCH-1:0][Q_W-1:0]    quot_next  [DIV_STEPS+1];

    always_comb begin
        logic [MAX_W:0] t;
        logic [MAX_W:0] d;
        logic           ge;
        for (int c = 0; c < NCH; c++) begin
            ge = (dv_in[c] == max_reg[c]);
            rem_next[0][c]  = ge ? '0 : dv_in[c];
            quot_next[0][c] = {{(Q_W-1){1'b0}}, ge};
        end
        for (int k = 1; k <= DIV_STEPS; k++) begin
            for (int c = 0; c < NCH; c++) begin
                t  = {rem_reg[k-1][c], 1'b0};
                d  = t - {1'b0, max_reg[c]};
                ge = (t >= {1'b0, max_reg[c]});
                rem_next[k][c]  = ge ? d[MAX_W-1:0] : t[MAX_W-1:0];
                quot_next[k][c] = {quot_reg[k-1][c][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dvalid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dvalid_reg[0] <= s_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                dvalid_reg[k] <= dvalid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmeta_reg[0] <= meta_in;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                dmeta_reg[k] <= dmeta_reg[k-1];
            end
            for (int k = 0; k <= DIV_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    // hue stage 1: normalized levels, sector and fraction
    logic                      h1_valid_reg;
    meta_t                     h1_meta_reg;
    logic [NCH-1:0][Q_W-1:0]   h1_norm_reg;
    logic [2:0]                h1_sector_reg;
    logic [15:0]               h1_f_reg;
    logic [NCH-1:0][Q_W-1:0]   norm_next;
    logic [18:0]               w_next;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            norm_next[c] = (max_reg[c] == '0) ? '0 : quot_reg[DIV_STEPS][c];
        end
        w_next = {1'b0, norm_next[CH_X][15:0], 2'b00}
               + {2'b00, norm_next[CH_X][15:0], 1'b0};
    end

    // hue stage 2: s*f, s*(1-f), p
    logic                      h2_valid_reg;
    meta_t                     h2_meta_reg;
    logic [NCH-1:0][Q_W-1:0]   h2_norm_reg;
    logic [2:0]                h2_sector_reg;
    logic [Q_W-1:0]            h2_sf_reg;
    logic [Q_W-1:0]            h2_sf1_reg;
    logic [Q_W-1:0]            h2_p_reg;
    logic [2*Q_W-1:0]          sf_prod;
    logic [2*Q_W-1:0]          sf1_prod;
    logic [2*Q_W-1:0]          p_prod;

    always_comb begin
        sf_prod  = h1_norm_reg[CH_Y] * {1'b0, h1_f_reg};
        sf1_prod = h1_norm_reg[CH_Y] * (ONE_Q16 - {1'b0, h1_f_reg});
        p_prod   = h1_norm_reg[CH_Z] * (ONE_Q16 - h1_norm_reg[CH_Y]);
    end

    // hue stage 3: q, t and the scaled alpha byte of a packed color
    logic                      h3_valid_reg;
    meta_t                     h3_meta_reg;
    logic [NCH-1:0][Q_W-1:0]   h3_norm_reg;
    logic [2:0]                h3_sector_reg;
    logic [Q_W-1:0]            h3_p_reg;
    logic [Q_W-1:0]            h3_q_reg;
    logic [Q_W-1:0]            h3_t_reg;
    logic [7:0]                h3_ab_reg;
    logic [2*Q_W-1:0]          q_prod;
    logic [2*Q_W-1:0]          t_prod;
    logic [Q_W-1:0]            ratio;
    logic [Q_W+7:0]            ab_prod;
    logic [7:0]                ab_next;

    always_comb begin
        q_prod = h2_norm_reg[CH_Z] * (ONE_Q16 - h2_sf_reg);
        t_prod = h2_norm_reg[CH_Z] * (ONE_Q16 - h2_sf1_reg);
        if (max_reg[CH_A] == '0) begin
            ratio = h2_meta_reg.alpha_pos ? ONE_Q16 : '0;
        end else begin
            ratio = h2_norm_reg[CH_A];
        end
        ab_prod = h2_meta_reg.pc[31:24] * ratio;
        ab_next = (|ab_prod[Q_W+7:24]) ? 8'hff : ab_prod[23:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
            h3_valid_reg <= 1'b0;
        end else if (en) begin
            h1_valid_reg <= dvalid_reg[DIV_STEPS];
            h2_valid_reg <= h1_valid_reg;
            h3_valid_reg <= h2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_meta_reg   <= dmeta_reg[DIV_STEPS];
            h1_norm_reg   <= norm_next;
            h1_sector_reg <= w_next[18:16];
            h1_f_reg      <= w_next[15:0];
            h2_meta_reg   <= h1_meta_reg;
            h2_norm_reg   <= h1_norm_reg;
            h2_sector_reg <= h1_sector_reg;
            h2_sf_reg     <= sf_prod[FRAC_Q+Q_W-1:FRAC_Q];
            h2_sf1_reg    <= sf1_prod[FRAC_Q+Q_W-1:FRAC_Q];
            h2_p_reg      <= p_prod[FRAC_Q+Q_W-1:FRAC_Q];
            h3_meta_reg   <= h2_meta_reg;
            h3_norm_reg   <= h2_norm_reg;
            h3_sector_reg <= h2_sector_reg;
            h3_p_reg      <= h2_p_reg;
            h3_q_reg      <= q_prod[FRAC_Q+Q_W-1:FRAC_Q];
            h3_t_reg      <= t_prod[FRAC_Q+Q_W-1:FRAC_Q];
            h3_ab_reg     <= ab_next;
        end
    end

    // output stage: pick levels, convert to bytes, pack
    logic [NCH-1:0][LVL_W-1:0] lvl;
    logic [Q_W-1:0]            hr;
    logic [Q_W-1:0]            hg;
    logic [Q_W-1:0]            hb;
    logic [7:0]                byte_a;
    logic [7:0]                byte_r;
    logic [7:0]                byte_g;
    logic [7:0]                byte_b;
    logic [7:0]                byte_gray;
    logic [31:0]               argb_next;
    logic [LVL_W-1:0]          hr_l;
    logic [LVL_W-1:0]          hg_l;
    logic [LVL_W-1:0]          hb_l;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (scale_enable_reg) begin
                lvl[c] = {{(LVL_W-Q_W){1'b0}}, h3_norm_reg[c]};
            end else begin
                lvl[c] = LVL_W'(h3_meta_reg.cval[c]) << SH;
            end
        end
        hr = h3_norm_reg[CH_Z];
        hg = h3_norm_reg[CH_Z];
        hb = h3_norm_reg[CH_Z];
        if (h3_norm_reg[CH_Y] != '0) begin
            case (h3_sector_reg)
                3'd0: begin hr = h3_norm_reg[CH_Z]; hg = h3_t_reg; hb = h3_p_reg; end
                3'd1: begin hr = h3_q_reg; hg = h3_norm_reg[CH_Z]; hb = h3_p_reg; end
                3'd2: begin hr = h3_p_reg; hg = h3_norm_reg[CH_Z]; hb = h3_t_reg; end
                3'd3: begin hr = h3_p_reg; hg = h3_q_reg; hb = h3_norm_reg[CH_Z]; end
                3'd4: begin hr = h3_t_reg; hg = h3_p_reg; hb = h3_norm_reg[CH_Z]; end
                default: begin hr = h3_norm_reg[CH_Z]; hg = h3_p_reg; hb = h3_q_reg; end
            endcase
        end
        hr_l      = {{(LVL_W-Q_W){1'b0}}, hr};
        hg_l      = {{(LVL_W-Q_W){1'b0}}, hg};
        hb_l      = {{(LVL_W-Q_W){1'b0}}, hb};
        byte_a    = to_byte(lvl[CH_A]);
        byte_gray = to_byte(lvl[CH_X]);
        if (color_mode_reg) begin
            byte_r = to_byte(hr_l);
            byte_g = to_byte(hg_l);
            byte_b = to_byte(hb_l);
        end else begin
            byte_r = to_byte(lvl[CH_X]);
            byte_g = to_byte(lvl[CH_Y]);
            byte_b = to_byte(lvl[CH_Z]);
        end
        case (h3_meta_reg.kind)
            K_GRAY:  argb_next = {byte_a, byte_gray, byte_gray, byte_gray};
            K_THREE: argb_next = {byte_a, byte_r, byte_g, byte_b};
            K_PASS:  argb_next = h3_meta_reg.alpha_eq ? h3_meta_reg.pc
                                 : {h3_ab_reg, h3_meta_reg.pc[23:0]};
            default: argb_next = '0;
        endcase
    end

    // output register
    logic        m_valid_reg;
    logic [31:0] m_argb_reg;
    logic        m_trans_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= h3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_argb_reg  <= argb_next;
            m_trans_reg <= (h3_meta_reg.kind == K_NONE) || (argb_next[31:24] != 8'hff);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_argb        = m_argb_reg;
    assign m_translucent = m_trans_reg;

endmodule

// ----- rtl/core/ctap_checker.sv -----
// port-level checks of the color to argb packer
module ctap_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_argb,
    input logic        m_translucent
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_argb) && $stable(m_translucent))
        else $error("result beat changed under stall");

    // flag follows the alpha byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_translucent == (m_argb[31:24] != 8'hff)))
        else $error("translucent flag disagrees with alpha byte");

    // input side never blocks while the output is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with output free");

    // reset empties the pipe
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind color_to_argb_packer ctap_checker u_ctap_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_argb        (m_argb),
    .m_translucent (m_translucent)
);
